### rtl/ohm_pkg.sv
// Shared constants, types and helper functions for the ordered hash map.
`timescale 1ns / 1ps
package ohm_pkg;

    localparam int MIN_SLOTS = 8;
    localparam int MAX_SLOTS = 1024;
    localparam int IDX_W     = $clog2(MAX_SLOTS);
    localparam int ADDR_W    = IDX_W + 1;
    localparam int SZ_W      = IDX_W + 1;
    localparam int SLOT_W    = 11;
    localparam int KEY_W     = 64;
    localparam int VAL_W     = 64;
    localparam int HASH_W    = 32;

    typedef logic [IDX_W-1:0]         idx_t;
    typedef logic [SZ_W-1:0]          size_t;
    typedef logic signed [SLOT_W-1:0] slot_t;

    localparam slot_t NO_SLOT = '1;

    typedef enum logic [1:0] {
        FN_SET  = 2'd0,
        FN_GET  = 2'd1,
        FN_DROP = 2'd2,
        FN_NEXT = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_INSERTED = 3'd0,
        ST_UPDATED  = 3'd1,
        ST_FOUND    = 3'd2,
        ST_ABSENT   = 3'd3,
        ST_DROPPED  = 3'd4,
        ST_FULL     = 3'd5,
        ST_END      = 3'd6
    } status_t;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [VAL_W-1:0]  value;
        logic [HASH_W-1:0] hash;
        slot_t             prev;
        slot_t             next;
        logic              used;
    } entry_t;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic              en_key;
        logic              en_value;
        logic              en_hash;
        logic              en_prev;
        logic              en_next;
        logic              en_used;
        entry_t            data;
    } wr_t;

    // A slot is valid when it is not negative and lies inside the table.
    function automatic logic slot_ok(slot_t s, size_t size);
        return !s[SLOT_W-1] && (SZ_W'($unsigned(s)) < size);
    endfunction

    function automatic slot_t idx2slot(idx_t i);
        return slot_t'({{(SLOT_W-IDX_W){1'b0}}, i});
    endfunction

    function automatic idx_t mask_of(size_t size);
        return IDX_W'(size - SZ_W'(1));
    endfunction

endpackage

### rtl/ohm_req_if.sv
// Request channel: one map operation per item.
`timescale 1ns / 1ps
interface ohm_req_if import ohm_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [1:0]               func;
    logic [KEY_W-1:0]         key_value;
    logic signed [HASH_W-1:0] key_hash;
    logic [VAL_W-1:0]         data_value;
    logic signed [SLOT_W-1:0] cursor;

    modport source (output valid, func, key_value, key_hash, data_value, cursor,
                    input ready);
    modport sink   (input valid, func, key_value, key_hash, data_value, cursor,
                    output ready);
endinterface

### rtl/ohm_rsp_if.sv
// Response channel: one result item per operation.
`timescale 1ns / 1ps
interface ohm_rsp_if import ohm_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [2:0]               status;
    logic [VAL_W-1:0]         out_value;
    logic [KEY_W-1:0]         out_key;
    logic signed [SLOT_W-1:0] slot;
    logic [SZ_W-1:0]          entry_count;

    modport source (output valid, status, out_value, out_key, slot, entry_count,
                    input ready);
    modport sink   (input valid, status, out_value, out_key, slot, entry_count,
                    output ready);
endinterface

### rtl/ordered_hash_map_top.sv
// Top level of the insertion-ordered hash map: sequencer, storage and probe unit.
`timescale 1ns / 1ps
// The block keeps up to 768 entries of 64-bit key and 64-bit value in an
// open-addressed table whose size is a power of two between MIN_SLOTS and
// MAX_SLOTS, and links them in insertion order so that the next operation can
// walk them. The largest table refuses a new key once three quarters of its
// slots are taken. One item is handled at a time; the request side is ready
// only while the sequencer is idle, and a finished result may wait in the
// output register while the next item is taken. Every probe step passes
// through a read state and a check state because the read of the slot
// storage is registered. A drop that finds its key always rebuilds the
// table, and a set rebuilds it when the load rules call for growth or
// shrinkage; a rebuild clears the used marks of every slot of the new table,
// then reads each entry in list order, probes for its place in the new table
// and writes and links it there, and ends by switching banks. After reset the
// starting table is cleared, and no item is accepted until that is done. The
// hash comes with the key, and keys match only when bitwise equal.
module ordered_hash_map_top import ohm_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    ohm_req_if.sink   req,
    ohm_rsp_if.source rsp
);

    typedef enum logic [4:0] {
        S_IDLE, S_CLR, S_PR_RD, S_PR_CHK, S_LINK, S_RSZ,
        S_RB_TEST, S_RB_RD, S_RB_LAT, S_RB_WR, S_RB_LINK, S_RB_END,
        S_CU_RD, S_CU_CHK, S_NX_TEST, S_NX_RD, S_NX_CHK, S_DONE
    } state_t;

    state_t            state_reg;
    func_t             func_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [VAL_W-1:0]  data_reg;
    logic [HASH_W-1:0] hash_reg;
    slot_t             cursor_reg;

    // Probe control
    idx_t        i_reg;
    logic [63:0] pert_reg;
    idx_t        pmask_reg;
    logic        pbank_reg;
    logic        match_reg;
    logic        rb_reg;

    // Map state
    logic  bank_reg;
    size_t size_reg;
    size_t count_reg;
    slot_t first_reg;
    slot_t last_reg;

    // Rebuild and link scratch
    size_t ns_reg;
    size_t clr_reg;
    logic  init_reg;
    logic  force_reg;
    slot_t cur_reg;
    slot_t nxt_reg;
    slot_t prev_reg;
    slot_t head_reg;
    slot_t moved_reg;
    size_t n_reg;
    slot_t w_reg;
    slot_t pv_reg;

    // Result held until the output register is free
    status_t          res_status_reg;
    logic [VAL_W-1:0] res_val_reg;
    logic [KEY_W-1:0] res_key_reg;
    slot_t            res_slot_reg;

    logic             o_valid_reg;
    status_t          o_status_reg;
    logic [VAL_W-1:0] o_val_reg;
    logic [KEY_W-1:0] o_key_reg;
    slot_t            o_slot_reg;
    size_t            o_count_reg;

    idx_t        i_next;
    logic [63:0] pert_next;
    wr_t         wr;
    logic [ADDR_W-1:0] rd_addr;
    entry_t      rd;

    logic hit;
    logic stop;
    logic full;
    logic grow;
    logic shrink;
    logic clr_bank;
    logic signed [SZ_W+1:0] free_ins;
    logic signed [SZ_W+1:0] free_now;
    logic signed [SZ_W+1:0] quarter;

    ohm_probe u_probe
    (
        .idx       (i_reg),
        .pert      (pert_reg),
        .mask      (pmask_reg),
        .idx_next  (i_next),
        .pert_next (pert_next)
    );

    ohm_store u_store
    (
        .clk     (clk),
        .wr      (wr),
        .rd_addr (rd_addr),
        .rd_data (rd)
    );

    assign hit  = rd.used && match_reg && (rd.key == key_reg);
    assign stop = !rd.used || hit;

    // Load rules; a new key at the largest size is refused instead of growing.
    assign quarter  = $signed({2'b00, size_reg >> 2});
    assign free_ins = $signed({2'b00, size_reg}) - $signed({2'b00, count_reg})
                      - (SZ_W+2)'(1);
    assign free_now = $signed({2'b00, size_reg}) - $signed({2'b00, count_reg});
    assign full     = (free_ins < quarter) && (size_reg == SZ_W'(MAX_SLOTS));
    assign grow     = (free_now < quarter) && (size_reg < SZ_W'(MAX_SLOTS));
    assign shrink   = (size_reg > SZ_W'(MIN_SLOTS))
                      && ($signed({2'b00, count_reg}) <= quarter);
    assign clr_bank = bank_reg ^ !init_reg;

    always_comb
    begin
        rd_addr = '0;
        unique case (state_reg)
            S_PR_RD: rd_addr = {pbank_reg, i_reg};
            S_RB_RD: rd_addr = {bank_reg, cur_reg[IDX_W-1:0]};
            S_CU_RD: rd_addr = {bank_reg, cursor_reg[IDX_W-1:0]};
            S_NX_RD: rd_addr = {bank_reg, cur_reg[IDX_W-1:0]};
            default: rd_addr = '0;
        endcase
    end

    always_comb
    begin
        wr = '0;
        wr.data.key   = key_reg;
        wr.data.value = data_reg;
        wr.data.hash  = hash_reg;
        wr.data.next  = NO_SLOT;
        unique case (state_reg)
            S_PR_CHK:
            begin
                if (!rb_reg && stop && (func_reg == FN_SET))
                begin
                    wr.addr = {bank_reg, i_reg};
                    if (hit)
                    begin
                        wr.en_value = 1'b1;
                        wr.en_hash  = 1'b1;
                    end
                    else if (!full)
                    begin
                        wr.en_key    = 1'b1;
                        wr.en_value  = 1'b1;
                        wr.en_hash   = 1'b1;
                        wr.en_prev   = 1'b1;
                        wr.en_next   = 1'b1;
                        wr.en_used   = 1'b1;
                        wr.data.prev = last_reg;
                        wr.data.used = 1'b1;
                    end
                end
            end
            S_LINK:
            begin
                wr.addr      = {bank_reg, pv_reg[IDX_W-1:0]};
                wr.en_next   = 1'b1;
                wr.data.next = w_reg;
            end
            S_CLR:
            begin
                wr.addr    = {clr_bank, clr_reg[IDX_W-1:0]};
                wr.en_used = 1'b1;
            end
            S_RB_WR:
            begin
                wr.addr      = {!bank_reg, w_reg[IDX_W-1:0]};
                wr.en_key    = 1'b1;
                wr.en_value  = 1'b1;
                wr.en_hash   = 1'b1;
                wr.en_prev   = 1'b1;
                wr.en_next   = 1'b1;
                wr.en_used   = 1'b1;
                wr.data.prev = prev_reg;
                wr.data.used = 1'b1;
            end
            S_RB_LINK:
            begin
                wr.addr      = {!bank_reg, pv_reg[IDX_W-1:0]};
                wr.en_next   = 1'b1;
                wr.data.next = w_reg;
            end
            default: wr.addr = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLR;
            func_reg       <= FN_SET;
            key_reg        <= '0;
            data_reg       <= '0;
            hash_reg       <= '0;
            cursor_reg     <= NO_SLOT;
            i_reg          <= '0;
            pert_reg       <= '0;
            pmask_reg      <= '0;
            pbank_reg      <= 1'b0;
            match_reg      <= 1'b0;
            rb_reg         <= 1'b0;
            bank_reg       <= 1'b0;
            size_reg       <= SZ_W'(MIN_SLOTS);
            count_reg      <= '0;
            first_reg      <= NO_SLOT;
            last_reg       <= NO_SLOT;
            ns_reg         <= SZ_W'(MIN_SLOTS);
            clr_reg        <= '0;
            init_reg       <= 1'b1;
            force_reg      <= 1'b0;
            cur_reg        <= NO_SLOT;
            nxt_reg        <= NO_SLOT;
            prev_reg       <= NO_SLOT;
            head_reg       <= NO_SLOT;
            moved_reg      <= NO_SLOT;
            n_reg          <= '0;
            w_reg          <= NO_SLOT;
            pv_reg         <= NO_SLOT;
            res_status_reg <= ST_ABSENT;
            res_val_reg    <= '0;
            res_key_reg    <= '0;
            res_slot_reg   <= NO_SLOT;
            o_valid_reg    <= 1'b0;
            o_status_reg   <= ST_ABSENT;
            o_val_reg      <= '0;
            o_key_reg      <= '0;
            o_slot_reg     <= NO_SLOT;
            o_count_reg    <= '0;
        end
        else
        begin
            // The completion state reloads the output register itself.
            if (o_valid_reg && rsp.ready && (state_reg != S_DONE))
            begin
                o_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        func_reg       <= func_t'(req.func);
                        key_reg        <= req.key_value;
                        data_reg       <= req.data_value;
                        hash_reg       <= req.key_hash;
                        cursor_reg     <= req.cursor;
                        res_val_reg    <= '0;
                        res_key_reg    <= '0;
                        res_slot_reg   <= NO_SLOT;
                        i_reg          <= req.key_hash[IDX_W-1:0] & mask_of(size_reg);
                        pert_reg       <= {{32{req.key_hash[HASH_W-1]}}, req.key_hash};
                        pmask_reg      <= mask_of(size_reg);
                        pbank_reg      <= bank_reg;
                        match_reg      <= 1'b1;
                        rb_reg         <= 1'b0;
                        if (func_t'(req.func) != FN_NEXT)
                        begin
                            res_status_reg <= ST_ABSENT;
                            state_reg      <= S_PR_RD;
                        end
                        else if (req.cursor == NO_SLOT)
                        begin
                            res_status_reg <= ST_ABSENT;
                            cur_reg        <= first_reg;
                            state_reg      <= S_NX_TEST;
                        end
                        else if (slot_ok(req.cursor, size_reg))
                        begin
                            res_status_reg <= ST_ABSENT;
                            state_reg      <= S_CU_RD;
                        end
                        else
                        begin
                            res_status_reg <= ST_END;
                            state_reg      <= S_DONE;
                        end
                    end
                end

                // Clears the used marks of the table about to be filled.
                S_CLR:
                begin
                    if (clr_reg + SZ_W'(1) == ns_reg)
                    begin
                        clr_reg <= '0;
                        if (init_reg)
                        begin
                            init_reg  <= 1'b0;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            state_reg <= S_RB_TEST;
                        end
                    end
                    else
                    begin
                        clr_reg <= clr_reg + SZ_W'(1);
                    end
                end

                S_PR_RD:
                begin
                    state_reg <= S_PR_CHK;
                end

                S_PR_CHK:
                begin
                    if (!stop)
                    begin
                        i_reg     <= i_next;
                        pert_reg  <= pert_next;
                        state_reg <= S_PR_RD;
                    end
                    else if (rb_reg)
                    begin
                        w_reg     <= idx2slot(i_reg);
                        state_reg <= S_RB_WR;
                    end
                    else
                    begin
                        case (func_reg)
                            FN_SET:
                            begin
                                force_reg <= 1'b0;
                                if (hit)
                                begin
                                    res_status_reg <= ST_UPDATED;
                                    res_slot_reg   <= idx2slot(i_reg);
                                    state_reg      <= S_RSZ;
                                end
                                else if (full)
                                begin
                                    res_status_reg <= ST_FULL;
                                    state_reg      <= S_DONE;
                                end
                                else
                                begin
                                    res_status_reg <= ST_INSERTED;
                                    res_slot_reg   <= idx2slot(i_reg);
                                    pv_reg         <= last_reg;
                                    w_reg          <= idx2slot(i_reg);
                                    last_reg       <= idx2slot(i_reg);
                                    count_reg      <= count_reg + SZ_W'(1);
                                    if (slot_ok(last_reg, size_reg))
                                    begin
                                        state_reg <= S_LINK;
                                    end
                                    else
                                    begin
                                        first_reg <= idx2slot(i_reg);
                                        state_reg <= S_RSZ;
                                    end
                                end
                            end
                            FN_GET:
                            begin
                                if (hit)
                                begin
                                    res_status_reg <= ST_FOUND;
                                    res_val_reg    <= rd.value;
                                    res_slot_reg   <= idx2slot(i_reg);
                                end
                                state_reg <= S_DONE;
                            end
                            default:
                            begin
                                if (hit)
                                begin
                                    // The old bank is abandoned by the rebuild, so
                                    // only the forward link needs mending.
                                    res_status_reg <= ST_DROPPED;
                                    res_slot_reg   <= idx2slot(i_reg);
                                    force_reg      <= 1'b1;
                                    if (count_reg != '0)
                                    begin
                                        count_reg <= count_reg - SZ_W'(1);
                                    end
                                    pv_reg <= rd.prev;
                                    w_reg  <= rd.next;
                                    if (slot_ok(rd.prev, size_reg))
                                    begin
                                        state_reg <= S_LINK;
                                    end
                                    else
                                    begin
                                        first_reg <= rd.next;
                                        state_reg <= S_RSZ;
                                    end
                                end
                                else
                                begin
                                    state_reg <= S_DONE;
                                end
                            end
                        endcase
                    end
                end

                S_LINK:
                begin
                    state_reg <= S_RSZ;
                end

                S_RSZ:
                begin
                    cur_reg   <= first_reg;
                    prev_reg  <= NO_SLOT;
                    head_reg  <= NO_SLOT;
                    moved_reg <= NO_SLOT;
                    n_reg     <= '0;
                    clr_reg   <= '0;
                    if (grow)
                    begin
                        ns_reg    <= SZ_W'(size_reg << 1);
                        state_reg <= S_CLR;
                    end
                    else if (shrink)
                    begin
                        ns_reg    <= size_reg >> 1;
                        state_reg <= S_CLR;
                    end
                    else if (force_reg)
                    begin
                        ns_reg    <= size_reg;
                        state_reg <= S_CLR;
                    end
                    else
                    begin
                        state_reg <= S_DONE;
                    end
                end

                S_RB_TEST:
                begin
                    if ((n_reg < count_reg) && slot_ok(cur_reg, size_reg))
                    begin
                        state_reg <= S_RB_RD;
                    end
                    else
                    begin
                        state_reg <= S_RB_END;
                    end
                end

                S_RB_RD:
                begin
                    state_reg <= S_RB_LAT;
                end

                S_RB_LAT:
                begin
                    key_reg   <= rd.key;
                    data_reg  <= rd.value;
                    hash_reg  <= rd.hash;
                    nxt_reg   <= rd.next;
                    i_reg     <= rd.hash[IDX_W-1:0] & mask_of(ns_reg);
                    pert_reg  <= {{32{rd.hash[HASH_W-1]}}, rd.hash};
                    pmask_reg <= mask_of(ns_reg);
                    pbank_reg <= !bank_reg;
                    match_reg <= 1'b0;
                    rb_reg    <= 1'b1;
                    state_reg <= S_PR_RD;
                end

                S_RB_WR:
                begin
                    if (cur_reg == res_slot_reg)
                    begin
                        moved_reg <= w_reg;
                    end
                    prev_reg <= w_reg;
                    cur_reg  <= nxt_reg;
                    n_reg    <= n_reg + SZ_W'(1);
                    if (prev_reg != NO_SLOT)
                    begin
                        pv_reg    <= prev_reg;
                        state_reg <= S_RB_LINK;
                    end
                    else
                    begin
                        head_reg  <= w_reg;
                        state_reg <= S_RB_TEST;
                    end
                end

                S_RB_LINK:
                begin
                    state_reg <= S_RB_TEST;
                end

                S_RB_END:
                begin
                    count_reg <= n_reg;
                    bank_reg  <= !bank_reg;
                    size_reg  <= ns_reg;
                    first_reg <= head_reg;
                    last_reg  <= prev_reg;
                    if (func_reg == FN_SET)
                    begin
                        res_slot_reg <= moved_reg;
                    end
                    state_reg <= S_DONE;
                end

                S_CU_RD:
                begin
                    state_reg <= S_CU_CHK;
                end

                S_CU_CHK:
                begin
                    if (rd.used)
                    begin
                        cur_reg   <= rd.next;
                        state_reg <= S_NX_TEST;
                    end
                    else
                    begin
                        res_status_reg <= ST_END;
                        state_reg      <= S_DONE;
                    end
                end

                S_NX_TEST:
                begin
                    if (slot_ok(cur_reg, size_reg))
                    begin
                        state_reg <= S_NX_RD;
                    end
                    else
                    begin
                        res_status_reg <= ST_END;
                        state_reg      <= S_DONE;
                    end
                end

                S_NX_RD:
                begin
                    state_reg <= S_NX_CHK;
                end

                S_NX_CHK:
                begin
                    if (rd.used)
                    begin
                        res_status_reg <= ST_FOUND;
                        res_val_reg    <= rd.value;
                        res_key_reg    <= rd.key;
                        res_slot_reg   <= cur_reg;
                    end
                    else
                    begin
                        res_status_reg <= ST_END;
                    end
                    state_reg <= S_DONE;
                end

                S_DONE:
                begin
                    if (!o_valid_reg || rsp.ready)
                    begin
                        o_valid_reg  <= 1'b1;
                        o_status_reg <= res_status_reg;
                        o_val_reg    <= res_val_reg;
                        o_key_reg    <= res_key_reg;
                        o_slot_reg   <= res_slot_reg;
                        o_count_reg  <= count_reg;
                        state_reg    <= S_IDLE;
                    end
                end

                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign req.ready       = (state_reg == S_IDLE);
    assign rsp.valid       = o_valid_reg;
    assign rsp.status      = o_status_reg;
    assign rsp.out_value   = o_val_reg;
    assign rsp.out_key     = o_key_reg;
    assign rsp.slot        = o_slot_reg;
    assign rsp.entry_count = o_count_reg;

    // The table size stays a power of two inside its allowed range.
    a_size_pow2: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(size_reg) && size_reg >= SZ_W'(MIN_SLOTS)
        && size_reg <= SZ_W'(MAX_SLOTS))
        else $error("table size out of range");

    // The entry count never exceeds the table size.
    a_count_fits: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= size_reg)
        else $error("entry count exceeds table size");

    // A result is only presented from the completion state.
    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(o_valid_reg) |-> $past(state_reg) == S_DONE)
        else $error("result presented outside completion");

    // An entry is placed in the new table only at the end of a probe.
    a_rb_after_probe: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RB_WR |-> $past(state_reg) == S_PR_CHK && $past(rb_reg))
        else $error("rebuild write without a finished probe");

endmodule

### rtl/ohm_probe.sv
// Shared probe step unit: next slot index and shifted perturbation.
`timescale 1ns / 1ps
module ohm_probe import ohm_pkg::*;
(
    input  idx_t        idx,
    input  logic [63:0] pert,
    input  idx_t        mask,
    output idx_t        idx_next,
    output logic [63:0] pert_next
);

    idx_t sum;

    // Only the index bits survive the mask, so the sum is kept at that width.
    assign sum       = IDX_W'({idx, 2'b00}) + idx + IDX_W'(1) + pert[IDX_W-1:0];
    assign idx_next  = sum & mask;
    assign pert_next = pert >> 5;

endmodule

### rtl/ohm_store.sv
// Slot storage for both banks, one write address and one registered read.
`timescale 1ns / 1ps
module ohm_store import ohm_pkg::*;
(
    input  logic              clk,
    input  wr_t               wr,
    input  logic [ADDR_W-1:0] rd_addr,
    output entry_t            rd_data
);

    localparam int DEPTH = 2 ** ADDR_W;

    logic [KEY_W-1:0]  key_mem   [DEPTH];
    logic [VAL_W-1:0]  value_mem [DEPTH];
    logic [HASH_W-1:0] hash_mem  [DEPTH];
    slot_t             prev_mem  [DEPTH];
    slot_t             next_mem  [DEPTH];
    logic              used_mem  [DEPTH];
    entry_t            rd_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en_key)   key_mem[wr.addr]   <= wr.data.key;
        if (wr.en_value) value_mem[wr.addr] <= wr.data.value;
        if (wr.en_hash)  hash_mem[wr.addr]  <= wr.data.hash;
        if (wr.en_prev)  prev_mem[wr.addr]  <= wr.data.prev;
        if (wr.en_next)  next_mem[wr.addr]  <= wr.data.next;
        if (wr.en_used)  used_mem[wr.addr]  <= wr.data.used;
    end

    always_ff @(posedge clk)
    begin
        rd_reg.key   <= key_mem[rd_addr];
        rd_reg.value <= value_mem[rd_addr];
        rd_reg.hash  <= hash_mem[rd_addr];
        rd_reg.prev  <= prev_mem[rd_addr];
        rd_reg.next  <= next_mem[rd_addr];
        rd_reg.used  <= used_mem[rd_addr];
    end

    assign rd_data = rd_reg;

endmodule

### tb/sv/tb_ordered_hash_map_top.sv
// Self-checking testbench for the insertion-ordered hash map top level.
`timescale 1ns / 1ps
module tb_ordered_hash_map_top;
    import ohm_pkg::*;

    localparam int PROBE_LIMIT = MAX_SLOTS + 16;
    localparam int POOL_KEYS   = 48;

    // One request item as the sender sees it.
    typedef struct {
        func_t       func;
        logic [63:0] key;
        logic [31:0] hash;
        logic [63:0] data;
        logic [10:0] cursor;
    } op_item_t;

    // One result item, at the widths of the response channel.
    typedef struct {
        logic [2:0]  status;
        logic [63:0] value;
        logic [63:0] key;
        logic [10:0] slot;
        logic [10:0] count;
    } map_result_t;

    // A row of the directed table; the result is typed in only where known.
    typedef struct {
        op_item_t    item;
        bit          typed;
        map_result_t result;
    } stim_row_t;

    logic clk;
    logic rst_n;

    ohm_req_if req_ch ();
    ohm_rsp_if rsp_ch ();

    ordered_hash_map_top i_dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // The clock runs with a 10 ns period.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Shadow copy of the map: two banks of slots and the list bookkeeping.
    bit [63:0] m_key   [2*MAX_SLOTS];
    bit [63:0] m_value [2*MAX_SLOTS];
    bit [31:0] m_hash  [2*MAX_SLOTS];
    int        m_prev  [2*MAX_SLOTS];
    int        m_next  [2*MAX_SLOTS];
    bit        m_used  [2*MAX_SLOTS];
    bit        m_bank;
    int        m_size;
    int        m_count;
    int        m_first;
    int        m_last;

    map_result_t pending_results[$];
    stim_row_t   directed_rows[$];
    logic [63:0] pool_key  [POOL_KEYS];
    logic [31:0] pool_hash [POOL_KEYS];

    int  errors;
    int  items_sent;
    int  results_checked;
    int  full_seen;
    int  status_seen[8];
    int  walk_slot;
    int  burst_left;
    int  stall_left;
    int  quiet_left;

    function automatic int bank_base(bit b);
        return b ? MAX_SLOTS : 0;
    endfunction

    function automatic bit [63:0] widen(bit [31:0] h);
        return {{32{h[31]}}, h};
    endfunction

    function automatic bit slot_in(int s);
        return s >= 0 && s < m_size;
    endfunction

    // Returns 1 when the key was found, 0 at a free slot, -1 when the probe ran out.
    function automatic int table_probe(bit b, int size, bit [63:0] k, bit [63:0] h,
                                       bit want_match, output int where);
        bit [63:0] mask;
        bit [63:0] i;
        bit [63:0] perturb;
        int        p;
        int        n;
        mask    = 64'(size) - 64'd1;
        i       = h & mask;
        perturb = h;
        for (n = 0; n < PROBE_LIMIT; n++)
        begin
            p = bank_base(b) + int'(i);
            if (!m_used[p])
            begin
                where = int'(i);
                return 0;
            end
            if (want_match && m_key[p] == k)
            begin
                where = int'(i);
                return 1;
            end
            i       = (i * 64'd5 + 64'd1 + perturb) & mask;
            perturb = perturb >> 5;
        end
        where = -1;
        return -1;
    endfunction

    // Copies the entries in list order into the other bank at a new size.
    function automatic int rebuild_table(int new_size, int track);
        int ob;
        int nb;
        bit nbank;
        int cur;
        int prv;
        int head;
        int moved;
        int n;
        int op;
        int np;
        int w;
        ob    = bank_base(m_bank);
        nbank = ~m_bank;
        nb    = bank_base(nbank);
        cur   = m_first;
        prv   = -1;
        head  = -1;
        moved = -1;
        for (int k = 0; k < MAX_SLOTS; k++)
            m_used[nb + k] = 1'b0;
        for (n = 0; n < m_count && slot_in(cur); n++)
        begin
            op = ob + cur;
            if (table_probe(nbank, new_size, 64'd0, widen(m_hash[op]), 1'b0, w) != 0)
                break;
            np          = nb + w;
            m_key[np]   = m_key[op];
            m_value[np] = m_value[op];
            m_hash[np]  = m_hash[op];
            m_used[np]  = 1'b1;
            m_prev[np]  = prv;
            m_next[np]  = -1;
            if (prv != -1)
                m_next[nb + prv] = w;
            else
                head = w;
            if (cur == track)
                moved = w;
            prv = w;
            cur = m_next[op];
        end
        m_count = n;
        m_bank  = nbank;
        m_size  = new_size;
        m_first = head;
        m_last  = prv;
        return moved;
    endfunction

    function automatic int resize_table(bit force_it, int track);
        int ns;
        if (m_size - m_count < (m_size >> 2) && (m_size << 1) <= MAX_SLOTS)
            ns = m_size << 1;
        else if (m_size > MIN_SLOTS && (m_size >> 2) >= m_count)
            ns = m_size >> 1;
        else if (force_it)
            ns = m_size;
        else
            return track;
        return rebuild_table(ns, track);
    endfunction

    function automatic void map_reset();
        for (int k = 0; k < 2 * MAX_SLOTS; k++)
            m_used[k] = 1'b0;
        m_bank  = 1'b0;
        m_size  = MIN_SLOTS;
        m_count = 0;
        m_first = -1;
        m_last  = -1;
    endfunction

    // Applies one operation to the shadow map and returns the result it gives.
    function automatic map_result_t map_step(op_item_t it);
        map_result_t r;
        int          base;
        int          w;
        int          p;
        int          pv;
        int          nx;
        int          slot;
        int          cur;
        int          found;
        bit [63:0]   h;
        base     = bank_base(m_bank);
        h        = widen(it.hash);
        cur      = int'($signed(it.cursor));
        slot     = -1;
        r.status = ST_ABSENT;
        r.value  = '0;
        r.key    = '0;
        case (it.func)
            FN_SET:
            begin
                found = table_probe(m_bank, m_size, it.key, h, 1'b1, w);
                if (found == 1)
                begin
                    m_value[base + w] = it.data;
                    m_hash[base + w]  = it.hash;
                    r.status          = ST_UPDATED;
                    slot              = resize_table(1'b0, w);
                end
                else if (found == 0)
                begin
                    if (m_size - (m_count + 1) < (m_size >> 2) && (m_size << 1) > MAX_SLOTS)
                        r.status = ST_FULL;
                    else
                    begin
                        p          = base + w;
                        m_key[p]   = it.key;
                        m_value[p] = it.data;
                        m_hash[p]  = it.hash;
                        m_used[p]  = 1'b1;
                        m_prev[p]  = m_last;
                        m_next[p]  = -1;
                        if (slot_in(m_last))
                            m_next[base + m_last] = w;
                        else
                            m_first = w;
                        m_last   = w;
                        m_count++;
                        r.status = ST_INSERTED;
                        slot     = resize_table(1'b0, w);
                    end
                end
                else
                    r.status = ST_FULL;
            end
            FN_GET:
            begin
                if (table_probe(m_bank, m_size, it.key, h, 1'b1, w) == 1)
                begin
                    r.status = ST_FOUND;
                    r.value  = m_value[base + w];
                    slot     = w;
                end
            end
            FN_DROP:
            begin
                if (table_probe(m_bank, m_size, it.key, h, 1'b1, w) == 1)
                begin
                    p         = base + w;
                    pv        = m_prev[p];
                    nx        = m_next[p];
                    m_used[p] = 1'b0;
                    if (slot_in(nx))
                        m_prev[base + nx] = pv;
                    else
                        m_last = pv;
                    if (slot_in(pv))
                        m_next[base + pv] = nx;
                    else
                        m_first = nx;
                    if (m_count > 0)
                        m_count--;
                    r.status = ST_DROPPED;
                    slot     = w;
                    void'(resize_table(1'b1, -1));
                end
            end
            default:
            begin
                nx = -1;
                if (cur == -1)
                    nx = m_first;
                else if (slot_in(cur) && m_used[base + cur])
                    nx = m_next[base + cur];
                if (slot_in(nx) && m_used[base + nx])
                begin
                    r.status = ST_FOUND;
                    r.value  = m_value[base + nx];
                    r.key    = m_key[base + nx];
                    slot     = nx;
                end
                else
                    r.status = ST_END;
            end
        endcase
        r.slot  = 11'(slot);
        r.count = 11'(m_count);
        return r;
    endfunction

    function automatic void add_row(func_t f, logic [63:0] k, logic [31:0] h,
                                    logic [63:0] d, logic [10:0] c, bit typed,
                                    status_t st, logic [63:0] v, logic [63:0] ok,
                                    logic [10:0] s, logic [10:0] n);
        stim_row_t row;
        row.item.func     = f;
        row.item.key      = k;
        row.item.hash     = h;
        row.item.data     = d;
        row.item.cursor   = c;
        row.typed         = typed;
        row.result.status = st;
        row.result.value  = v;
        row.result.key    = ok;
        row.result.slot   = s;
        row.result.count  = n;
        directed_rows.push_back(row);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Drives one item, waits for the handshake, then runs the predictor.
    // The sender works in bursts; valid drops only between bursts.
    task automatic send_item(op_item_t it, bit typed, map_result_t typed_result);
        map_result_t r;
        req_ch.valid      <= 1'b1;
        req_ch.func       <= it.func;
        req_ch.key_value  <= it.key;
        req_ch.key_hash   <= it.hash;
        req_ch.data_value <= it.data;
        req_ch.cursor     <= it.cursor;
        do
            @(posedge clk);
        while (!req_ch.ready);
        r = map_step(it);
        pending_results.push_back(typed ? typed_result : r);
        items_sent++;
        if (r.status == ST_FULL)
            full_seen++;
        if (it.func == FN_NEXT)
            walk_slot = int'($signed(r.slot));
        if (burst_left > 0)
            burst_left--;
        else
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12))
                @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(0, 15);
        end
    endtask

    // Builds a random item; keys mostly come from a small pool so that
    // sets, gets and drops hit each other, and next mostly walks the list.
    function automatic op_item_t random_item(int drop_weight);
        op_item_t it;
        int       pick;
        int       sel;
        pick      = $urandom_range(0, POOL_KEYS - 1);
        it.key    = pool_key[pick];
        it.hash   = ($urandom_range(0, 7) == 0) ? $urandom : pool_hash[pick];
        it.data   = rand64();
        it.cursor = 11'(walk_slot);
        sel       = $urandom_range(0, 99);
        if (sel < 40 - drop_weight)
            it.func = FN_SET;
        else if (sel < 60 - drop_weight)
            it.func = FN_GET;
        else if (sel < 70)
            it.func = FN_DROP;
        else
            it.func = FN_NEXT;
        if ($urandom_range(0, 15) == 0)
        begin
            it.key  = rand64();
            it.hash = $urandom;
        end
        sel = $urandom_range(0, 19);
        if (sel < 3)
            it.cursor = '1;
        else if (sel < 6)
            it.cursor = 11'($urandom);
        return it;
    endfunction

    // Receiver: stalls come in short runs, with an occasional long quiet stretch.
    // Each accepted result is checked against the oldest expectation.
    always @(posedge clk)
    begin
        map_result_t e;
        if (rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: result item with nothing expected, status %0d", $time,
                         rsp_ch.status);
                errors++;
            end
            else
            begin
                e = pending_results.pop_front();
                results_checked++;
                status_seen[rsp_ch.status]++;
                if (rsp_ch.status !== e.status)
                begin
                    $display("%0t: status expected %0d actual %0d", $time, e.status,
                             rsp_ch.status);
                    errors++;
                end
                if (rsp_ch.out_value !== e.value)
                begin
                    $display("%0t: out_value expected %h actual %h", $time, e.value,
                             rsp_ch.out_value);
                    errors++;
                end
                if (rsp_ch.out_key !== e.key)
                begin
                    $display("%0t: out_key expected %h actual %h", $time, e.key,
                             rsp_ch.out_key);
                    errors++;
                end
                if (rsp_ch.slot !== e.slot)
                begin
                    $display("%0t: slot expected %0d actual %0d", $time, $signed(e.slot),
                             rsp_ch.slot);
                    errors++;
                end
                if (rsp_ch.entry_count !== e.count)
                begin
                    $display("%0t: entry_count expected %0d actual %0d", $time, e.count,
                             rsp_ch.entry_count);
                    errors++;
                end
            end
        end
        if (quiet_left > 0)
        begin
            quiet_left--;
            rsp_ch.ready <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            rsp_ch.ready <= 1'b1;
            if ($urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 8);
            else if ($urandom_range(0, 99) == 0)
                quiet_left = $urandom_range(100, 600);
        end
    end

    // Main sequence: reset, directed table, then three random phases.
    initial
    begin
        op_item_t    it;
        map_result_t none;
        int          fill_id;
        int          guard;
        rst_n             = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.func       = FN_SET;
        req_ch.key_value  = '0;
        req_ch.key_hash   = '0;
        req_ch.data_value = '0;
        req_ch.cursor     = '0;
        rsp_ch.ready      = 1'b0;
        errors            = 0;
        items_sent        = 0;
        results_checked   = 0;
        full_seen         = 0;
        walk_slot         = -1;
        burst_left        = 0;
        stall_left        = 0;
        quiet_left        = 0;
        none              = '{default: '0};
        foreach (status_seen[k])
            status_seen[k] = 0;
        map_reset();
        for (int k = 0; k < POOL_KEYS; k++)
        begin
            pool_key[k]  = rand64();
            // Few distinct low hash bits, so probe chains collide often.
            pool_hash[k] = ($urandom_range(0, 1) == 0)
                           ? {29'($urandom), 3'($urandom_range(0, 1))}
                           : $urandom;
        end

        // On an empty map next finds nothing and get is absent; the extreme
        // keys and hashes land at the ends of the minimum table; a drop
        // rebuilds and the survivor keeps its place.
        add_row(FN_NEXT, '0, '0, '0, '1, 1'b1, ST_END, '0, '0, '1, 11'd0);
        add_row(FN_GET, '1, '1, '0, '0, 1'b1, ST_ABSENT, '0, '0, '1, 11'd0);
        add_row(FN_DROP, '0, '0, '0, '0, 1'b1, ST_ABSENT, '0, '0, '1, 11'd0);
        add_row(FN_SET, '0, '0, 64'h1, '0, 1'b1, ST_INSERTED, '0, '0, 11'd0, 11'd1);
        add_row(FN_SET, '1, '1, '1, '0, 1'b1, ST_INSERTED, '0, '0, 11'd7, 11'd2);
        add_row(FN_GET, '1, '1, '0, '0, 1'b1, ST_FOUND, '1, '0, 11'd7, 11'd2);
        add_row(FN_SET, '0, '0, '1, '0, 1'b1, ST_UPDATED, '0, '0, 11'd0, 11'd2);
        add_row(FN_NEXT, '0, '0, '0, '1, 1'b0, ST_END, '0, '0, '0, '0);
        add_row(FN_NEXT, '0, '0, '0, 11'd0, 1'b0, ST_END, '0, '0, '0, '0);
        add_row(FN_NEXT, '0, '0, '0, 11'd7, 1'b0, ST_END, '0, '0, '0, '0);
        add_row(FN_DROP, '0, '0, '0, '0, 1'b1, ST_DROPPED, '0, '0, 11'd0, 11'd1);
        add_row(FN_NEXT, '0, '0, '0, '1, 1'b1, ST_FOUND, '1, '1, 11'd7, 11'd1);
        // A cursor past the table, the most negative cursor, and an unused slot.
        add_row(FN_NEXT, '0, '0, '0, 11'd1023, 1'b1, ST_END, '0, '0, '1, 11'd1);
        add_row(FN_NEXT, '0, '0, '0, 11'h400, 1'b1, ST_END, '0, '0, '1, 11'd1);
        add_row(FN_NEXT, '0, '0, '0, 11'd3, 1'b1, ST_END, '0, '0, '1, 11'd1);
        // Same key as a stored one but another hash: the hash is not compared
        // except to place the probe, so the result comes from the predictor.
        add_row(FN_SET, '1, 32'h8000_0000, 64'h5555_aaaa_5555_aaaa, '0, 1'b0,
                ST_END, '0, '0, '0, '0);
        add_row(FN_SET, 64'h8000_0000_0000_0000, 32'h7fff_ffff, '0, '0, 1'b0,
                ST_END, '0, '0, '0, '0);
        // Enough sets to grow the table, then drops that shrink it again.
        for (int k = 1; k <= 8; k++)
            add_row(FN_SET, 64'(k), 32'(k * 8), 64'(k), '0, 1'b0, ST_END, '0, '0, '0, '0);
        for (int k = 1; k <= 7; k++)
            add_row(FN_DROP, 64'(k), 32'(k * 8), '0, '0, 1'b0, ST_END, '0, '0, '0, '0);

        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[k])
            send_item(directed_rows[k].item, directed_rows[k].typed,
                      directed_rows[k].result);

        // Mixed traffic on a small table.
        repeat (300)
            send_item(random_item(0), 1'b0, none);

        // Fill with fresh keys until the largest table refuses new ones.
        fill_id = 0;
        guard   = 0;
        while (full_seen < 4 && guard < 1000)
        begin
            guard++;
            if ($urandom_range(0, 7) == 0)
            begin
                it      = random_item(0);
                it.func = ($urandom_range(0, 1) == 0) ? FN_GET : FN_NEXT;
            end
            else
            begin
                it.func   = FN_SET;
                it.key    = {32'(fill_id), $urandom};
                it.hash   = $urandom;
                it.data   = rand64();
                it.cursor = '1;
                fill_id++;
            end
            send_item(it, 1'b0, none);
        end

        // Drops and updates at the largest size; every drop that finds its key rebuilds.
        repeat (50)
            send_item(random_item(20), 1'b0, none);

        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (200)
            @(posedge clk);

        $display("Ran %0d items (%0d results checked): inserted %0d, updated %0d, found %0d,",
                 items_sent, results_checked, status_seen[ST_INSERTED],
                 status_seen[ST_UPDATED], status_seen[ST_FOUND]);
        $display("absent %0d, dropped %0d, full %0d, end of order %0d, mismatches %0d.",
                 status_seen[ST_ABSENT], status_seen[ST_DROPPED], status_seen[ST_FULL],
                 status_seen[ST_END], errors);
        if (errors == 0 && pending_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Watchdog: the slowest correct run stays well inside this window.
    initial
    begin
        #25ms;
        $display("%0t: timeout, %0d results still expected", $time, pending_results.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule

### filelist.f
rtl/ohm_pkg.sv
rtl/ohm_req_if.sv
rtl/ohm_rsp_if.sv
rtl/ohm_probe.sv
rtl/ohm_store.sv
rtl/ordered_hash_map_top.sv
tb/sv/tb_ordered_hash_map_top.sv
